### rtl/core/plist_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared constants, codes and the structs passed between the list modules.
// ----------------------------------------------------------------------------
package plist_pkg;

    // Capacity of the list and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of the request and result channels.
    localparam int MODE_W = 2;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 6;
    localparam int OCNT_W = 7;

    // Width of the position compares, one bit above the position itself.
    localparam int CMP_W  = POS_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_DISPLAY = 2'd2
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_DSP_RD,
        S_DSP_OUT,
        S_RESP
    } t_state;

    // Access to the list memory: one read and one write request.
    typedef struct packed {
        logic              rd_en;
        logic [AW-1:0]     rd_addr;
        logic              wr_en;
        logic [AW-1:0]     wr_addr;
        logic [DATA_W-1:0] wr_data;
    } t_ram_req;

    // One result as handed to the output register.
    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] entry_value;
        logic [IDX_W-1:0]         entry_index;
        logic                     last;
        logic [OCNT_W-1:0]        count;
    } t_result;

endpackage

### rtl/core/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// Positional list with insert and delete
// Ordered list of signed 32-bit values edited and listed by position.
// ----------------------------------------------------------------------------
// The block holds up to 64 signed values in order, in a memory with one write
// port and one registered read port, plus a count of stored entries. A
// request is taken only when o_stall is low, and each request runs to its
// end before the next is taken. An insert at position p into a list of n
// entries moves the entries from p to n up one place, one entry at a time
// through the memory (check, read, write), then writes the new value. A
// delete at position p moves entries p+1 to n down in the same way. A
// display reads one entry at a time and returns one result per entry, the
// final one marked by o_last; an empty list gives a single result with
// status empty. Refused requests (full, empty, bad position or unused mode)
// change nothing. The sequence follows from the single memory port and the
// one index adder that the sequencer steps through the list, and it waits
// while the output is held by i_stall. The output register lets a finished
// result wait while the sequencer carries on to its next memory access.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [plist_pkg::MODE_W-1:0]         i_mode,
    input  logic [plist_pkg::POS_W-1:0]          i_position,
    input  logic signed [plist_pkg::DATA_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [plist_pkg::STAT_W-1:0]         o_status,
    output logic signed [plist_pkg::DATA_W-1:0]  o_entry_value,
    output logic [plist_pkg::IDX_W-1:0]          o_entry_index,
    output logic                                 o_last,
    output logic [plist_pkg::OCNT_W-1:0]         o_count
);

    import plist_pkg::*;

    t_ram_req           w_ram;
    logic [DATA_W-1:0]  w_rd_data;
    logic               w_emit;
    t_result            w_result;
    logic               w_slot_free;

    logic               r_out_valid;
    t_result            r_out;

    // The result register may take a new result when empty or being drained.
    assign w_slot_free = !r_out_valid || !i_stall;

    plist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_slot_free (w_slot_free),
        .i_rd_data   (w_rd_data),
        .o_ram       (w_ram),
        .o_emit      (w_emit),
        .o_result    (w_result)
    );

    plist_ram #(
        .WIDTH   (DATA_W),
        .ENTRIES (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram.wr_en),
        .i_wr_addr (w_ram.wr_addr),
        .i_wr_data (w_ram.wr_data),
        .i_rd_en   (w_ram.rd_en),
        .i_rd_addr (w_ram.rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Output register: loaded when the sequencer emits, cleared once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out.status;
    assign o_entry_value = r_out.entry_value;
    assign o_entry_index = r_out.entry_index;
    assign o_last        = r_out.last;
    assign o_count       = r_out.count;

endmodule

### rtl/core/plist_ram.sv
// ----------------------------------------------------------------------------
// Positional list storage
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module plist_ram #(
    parameter int WIDTH   = 32,
    parameter int ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]           o_rd_data
);

    logic [WIDTH-1:0] r_mem [ENTRIES];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data holds until the next read so a stalled consumer keeps it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/plist_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list sequencer
// Walks the shared index unit over the memory to shift, remove and list.
// ----------------------------------------------------------------------------
module plist_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [plist_pkg::MODE_W-1:0]   i_mode,
    input  logic [plist_pkg::POS_W-1:0]    i_position,
    input  logic [plist_pkg::DATA_W-1:0]   i_value,
    input  logic                           i_slot_free,
    input  logic [plist_pkg::DATA_W-1:0]   i_rd_data,
    output plist_pkg::t_ram_req            o_ram,
    output logic                           o_emit,
    output plist_pkg::t_result             o_result
);

    import plist_pkg::*;

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [DATA_W-1:0]     r_value, n_value;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;
    t_status               r_status, n_status;

    logic                  w_accept;
    logic                  w_down;
    logic [CNT_W-1:0]      w_step;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic [CMP_W-1:0]      w_idx_x;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_bad;
    logic                  w_del_bad;
    logic                  w_ins_more;
    logic                  w_del_more;
    logic                  w_dsp_last;

    assign w_accept = i_valid && !o_stall;

    // Shared index unit: one step up or down, plus the loop compares.
    assign w_down  = (r_mode == MODE_INSERT);
    assign w_step  = w_down ? (r_idx - CNT_W'(1)) : (r_idx + CNT_W'(1));
    assign w_pos_x = CMP_W'(r_pos);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_idx_x = CMP_W'(r_idx);

    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_ins_bad  = (r_pos == '0) || (w_pos_x > (w_cnt_x + CMP_W'(1)));
    assign w_del_bad  = (r_pos == '0) || (w_pos_x > w_cnt_x);
    assign w_ins_more = (w_idx_x >= w_pos_x);
    assign w_del_more = (w_step < r_count);
    assign w_dsp_last = (w_step == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_mode)
                    MODE_INSERT: begin
                        n_state = (w_full || w_ins_bad) ? S_RESP : S_INS_CHK;
                    end
                    MODE_DELETE: begin
                        n_state = (w_empty || w_del_bad) ? S_RESP : S_DEL_CHK;
                    end
                    MODE_DISPLAY: begin
                        n_state = w_empty ? S_RESP : S_DSP_RD;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_INS_CHK: n_state = w_ins_more ? S_INS_RD : S_INS_PUT;
            S_INS_RD:  n_state = S_INS_WR;
            S_INS_WR:  n_state = S_INS_CHK;
            S_INS_PUT: n_state = S_RESP;
            S_DEL_CHK: n_state = w_del_more ? S_DEL_RD : S_RESP;
            S_DEL_RD:  n_state = S_DEL_WR;
            S_DEL_WR:  n_state = S_DEL_CHK;
            S_DSP_RD:  n_state = S_DSP_OUT;
            S_DSP_OUT: begin
                if (i_slot_free) begin
                    n_state = w_dsp_last ? S_IDLE : S_DSP_RD;
                end
            end
            S_RESP: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs: memory access, result emission and stall.
    always_comb begin
        o_stall             = (r_state != S_IDLE);
        o_ram.rd_en         = 1'b0;
        o_ram.rd_addr       = w_step[AW-1:0];
        o_ram.wr_en         = 1'b0;
        o_ram.wr_addr       = r_idx[AW-1:0];
        o_ram.wr_data       = i_rd_data;
        o_emit              = 1'b0;
        o_result.status     = r_status;
        o_result.entry_value = '0;
        o_result.entry_index = '0;
        o_result.last       = 1'b1;
        o_result.count      = OCNT_W'(r_count);
        case (r_state)
            S_INS_RD, S_DEL_RD: begin
                o_ram.rd_en = 1'b1;
            end
            S_INS_WR, S_DEL_WR: begin
                o_ram.wr_en = 1'b1;
            end
            S_INS_PUT: begin
                o_ram.wr_en   = 1'b1;
                o_ram.wr_data = r_value;
            end
            S_DSP_RD: begin
                o_ram.rd_en   = 1'b1;
                o_ram.rd_addr = r_idx[AW-1:0];
            end
            S_DSP_OUT: begin
                o_emit               = i_slot_free;
                o_result.status      = ST_OK;
                o_result.entry_value = i_rd_data;
                o_result.entry_index = IDX_W'(r_idx[AW-1:0]);
                o_result.last        = w_dsp_last;
            end
            S_RESP: begin
                o_emit = i_slot_free;
            end
            default: begin
            end
        endcase
    end

    // Datapath registers: request capture, index, count and status.
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_value  = r_value;
        n_idx    = r_idx;
        n_count  = r_count;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode  = i_mode;
                    n_pos   = i_position;
                    n_value = i_value;
                end
            end
            S_DECIDE: begin
                n_status = ST_OK;
                case (r_mode)
                    MODE_INSERT: begin
                        n_idx = r_count;
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else if (w_ins_bad) begin
                            n_status = ST_BADPOS;
                        end
                    end
                    MODE_DELETE: begin
                        n_idx = CNT_W'(r_pos) - CNT_W'(1);
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else if (w_del_bad) begin
                            n_status = ST_BADPOS;
                        end
                    end
                    MODE_DISPLAY: begin
                        n_idx = '0;
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end
                    end
                    default: begin
                        n_status = ST_BADPOS;
                    end
                endcase
            end
            S_INS_WR, S_DEL_WR: begin
                n_idx = w_step;
            end
            S_INS_PUT: begin
                n_count = r_count + CNT_W'(1);
            end
            S_DEL_CHK: begin
                if (!w_del_more) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_DSP_OUT: begin
                if (i_slot_free) begin
                    n_idx = w_step;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_status <= n_status;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond capacity");

    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_emit)
        else $error("result emitted while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECIDE) && o_stall)
        else $error("accepted request did not start the sequencer");

    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_PUT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_last_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && (r_state == S_DSP_OUT) && o_result.last)
            |-> (r_idx + CNT_W'(1) == r_count))
        else $error("last display result not at the end of the list");
`endif

endmodule
